// File: design/mwalu_pkg.sv
package mwalu_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned NARROW_W = 8;
    localparam int unsigned CMD_W = 3;
    localparam int unsigned REG_IDX_W = 4;

    localparam logic [CMD_W-1:0] CMD_SET  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUM  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_JNZ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NOP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_HALT = 3'd5;

    // register index map
    localparam logic [REG_IDX_W-1:0] REG_GEN0 = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_GEN1 = 4'd1;
    localparam logic [REG_IDX_W-1:0] REG_GEN2 = 4'd2;
    localparam logic [REG_IDX_W-1:0] REG_GEN3 = 4'd3;
    localparam logic [REG_IDX_W-1:0] REG_NAR0 = 4'd4;
    localparam logic [REG_IDX_W-1:0] REG_NAR1 = 4'd5;
    localparam logic [REG_IDX_W-1:0] REG_NAR2 = 4'd6;
    localparam logic [REG_IDX_W-1:0] REG_NAR3 = 4'd7;
    localparam logic [REG_IDX_W-1:0] REG_PC   = 4'd8;
    localparam logic [REG_IDX_W-1:0] REG_DI   = 4'd9;
    localparam logic [REG_IDX_W-1:0] REG_SI   = 4'd10;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [REG_IDX_W-1:0] dest_reg;
        logic [REG_IDX_W-1:0] src_reg;
        logic [DATA_W-1:0]    immediate;
    } instr_t;

    typedef struct packed {
        logic [DATA_W-1:0] next_pc;
        logic [DATA_W-1:0] dest_value;
        logic              halted;
    } result_t;

endpackage

// File: design/mwalu_exec.sv
module mwalu_exec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  mwalu_pkg::instr_t  instr,
    output mwalu_pkg::result_t result
);

    logic [mwalu_pkg::DATA_W-1:0]   gen_reg [4];
    logic [mwalu_pkg::NARROW_W-1:0] narrow_reg [4];
    logic [mwalu_pkg::DATA_W-1:0]   pc_reg;
    logic [mwalu_pkg::DATA_W-1:0]   di_reg;
    logic [mwalu_pkg::DATA_W-1:0]   si_reg;
    logic                           stopped_reg;

    logic [mwalu_pkg::DATA_W-1:0]   pc_view;
    logic [mwalu_pkg::DATA_W-1:0]   dst_val;
    logic [mwalu_pkg::DATA_W-1:0]   src_val;
    logic [mwalu_pkg::DATA_W-1:0]   wr_val;
    logic                           wr_en;
    logic                           dst_is_gen;
    logic                           dst_is_nar;
    logic                           dst_is_wide;
    logic [mwalu_pkg::DATA_W-1:0]   pc_next;
    logic                           stopped_next;
    logic [mwalu_pkg::DATA_W-1:0]   dest_out;

    // operand read; PC reads as its advanced value while running
    function automatic logic [mwalu_pkg::DATA_W-1:0] rd_reg(
        input logic [mwalu_pkg::REG_IDX_W-1:0] idx,
        input logic [mwalu_pkg::DATA_W-1:0]    g0,
        input logic [mwalu_pkg::DATA_W-1:0]    g1,
        input logic [mwalu_pkg::DATA_W-1:0]    g2,
        input logic [mwalu_pkg::DATA_W-1:0]    g3,
        input logic [mwalu_pkg::NARROW_W-1:0]  n0,
        input logic [mwalu_pkg::NARROW_W-1:0]  n1,
        input logic [mwalu_pkg::NARROW_W-1:0]  n2,
        input logic [mwalu_pkg::NARROW_W-1:0]  n3,
        input logic [mwalu_pkg::DATA_W-1:0]    pc,
        input logic [mwalu_pkg::DATA_W-1:0]    di,
        input logic [mwalu_pkg::DATA_W-1:0]    si
    );
        logic [mwalu_pkg::DATA_W-1:0] v;
        v = '0;
        case (idx)
            mwalu_pkg::REG_GEN0: v = g0;
            mwalu_pkg::REG_GEN1: v = g1;
            mwalu_pkg::REG_GEN2: v = g2;
            mwalu_pkg::REG_GEN3: v = g3;
            mwalu_pkg::REG_NAR0: v = {{(mwalu_pkg::DATA_W-mwalu_pkg::NARROW_W){1'b0}}, n0};
            mwalu_pkg::REG_NAR1: v = {{(mwalu_pkg::DATA_W-mwalu_pkg::NARROW_W){1'b0}}, n1};
            mwalu_pkg::REG_NAR2: v = {{(mwalu_pkg::DATA_W-mwalu_pkg::NARROW_W){1'b0}}, n2};
            mwalu_pkg::REG_NAR3: v = {{(mwalu_pkg::DATA_W-mwalu_pkg::NARROW_W){1'b0}}, n3};
            mwalu_pkg::REG_PC:   v = pc;
            mwalu_pkg::REG_DI:   v = di;
            mwalu_pkg::REG_SI:   v = si;
            default:             v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        pc_view = stopped_reg ? pc_reg : pc_reg + 32'd1;
        dst_val = rd_reg(instr.dest_reg, gen_reg[0], gen_reg[1], gen_reg[2], gen_reg[3],
                         narrow_reg[0], narrow_reg[1], narrow_reg[2], narrow_reg[3],
                         pc_view, di_reg, si_reg);
        src_val = rd_reg(instr.src_reg, gen_reg[0], gen_reg[1], gen_reg[2], gen_reg[3],
                         narrow_reg[0], narrow_reg[1], narrow_reg[2], narrow_reg[3],
                         pc_view, di_reg, si_reg);

        dst_is_gen  = (instr.dest_reg <= mwalu_pkg::REG_GEN3);
        dst_is_nar  = (instr.dest_reg >= mwalu_pkg::REG_NAR0)
                      && (instr.dest_reg <= mwalu_pkg::REG_NAR3);
        dst_is_wide = dst_is_gen || (instr.dest_reg == mwalu_pkg::REG_PC)
                      || (instr.dest_reg == mwalu_pkg::REG_DI)
                      || (instr.dest_reg == mwalu_pkg::REG_SI);

        wr_en        = 1'b0;
        wr_val       = instr.immediate;
        pc_next      = pc_view;
        stopped_next = stopped_reg;
        if (!stopped_reg)
        begin
            case (instr.command)
                mwalu_pkg::CMD_SET:
                begin
                    wr_en  = 1'b1;
                    wr_val = instr.immediate;
                end
                mwalu_pkg::CMD_SUM:
                begin
                    wr_en  = 1'b1;
                    wr_val = dst_val + src_val;
                end
                mwalu_pkg::CMD_SUB:
                begin
                    wr_en  = 1'b1;
                    wr_val = dst_val - src_val;
                end
                mwalu_pkg::CMD_JNZ:
                begin
                    if (dst_val != '0)
                        pc_next = instr.immediate;
                end
                mwalu_pkg::CMD_HALT:
                    stopped_next = 1'b1;
                default:
                    ;
            endcase
        end
        if (wr_en && (instr.dest_reg == mwalu_pkg::REG_PC))
            pc_next = wr_val;

        // destination as seen after the step
        if (wr_en && dst_is_nar)
            dest_out = {{(mwalu_pkg::DATA_W-mwalu_pkg::NARROW_W){1'b0}},
                        wr_val[mwalu_pkg::NARROW_W-1:0]};
        else if (wr_en && dst_is_wide)
            dest_out = wr_val;
        else if (instr.dest_reg == mwalu_pkg::REG_PC)
            dest_out = pc_next;
        else
            dest_out = dst_val;

        result.next_pc    = pc_next;
        result.dest_value = dest_out;
        result.halted     = stopped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                gen_reg[i]    <= '0;
                narrow_reg[i] <= '0;
            end
            pc_reg      <= '0;
            di_reg      <= '0;
            si_reg      <= '0;
            stopped_reg <= 1'b0;
        end
        else if (fire)
        begin
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
            if (wr_en)
            begin
                if (dst_is_gen)
                    gen_reg[instr.dest_reg[1:0]] <= wr_val;
                if (dst_is_nar)
                    narrow_reg[instr.dest_reg[1:0]] <= wr_val[mwalu_pkg::NARROW_W-1:0];
                if (instr.dest_reg == mwalu_pkg::REG_DI)
                    di_reg <= wr_val;
                if (instr.dest_reg == mwalu_pkg::REG_SI)
                    si_reg <= wr_val;
            end
        end
    end

endmodule

// File: design/mixed_width_register_alu_execute_top.sv
// Channel | Handshake             | Payload
// cmd     | cmd_valid / cmd_ready | mwalu_pkg::instr_t  (command, dest_reg, src_reg, immediate)
// res     | res_valid / res_ready | mwalu_pkg::result_t (next_pc, dest_value, halted)
//
// One instruction per cycle unless res stalls; res_valid comes via input then result reg.
// The input register feeds the execute logic, which writes the register file and the
// result register in the same cycle, so the next instruction sees the updated state.
// Reset clears all registers, PC and the halt flag.
// A stalled result holds the execute step; the input register still takes one more
// transaction if it is empty, then cmd_ready drops until res_ready returns.
module mixed_width_register_alu_execute_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mwalu_pkg::instr_t  cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output mwalu_pkg::result_t res
);

    logic               in_valid_reg;
    mwalu_pkg::instr_t  in_item_reg;
    logic               out_valid_reg;
    mwalu_pkg::result_t out_item_reg;
    logic               advance;
    mwalu_pkg::result_t exec_result;

    assign advance   = in_valid_reg && (!out_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;
    assign res_valid = out_valid_reg;
    assign res       = out_item_reg;

    mwalu_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .instr  (in_item_reg),
        .result (exec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
                in_valid_reg <= cmd_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
            in_item_reg <= cmd;
        if (advance)
            out_item_reg <= exec_result;
    end

endmodule
